FILE: rtl/mpa_pkg.sv
// Shared constants, codes and helper functions for the memory pool allocator.
// No dependencies.
package mpa_pkg;

  localparam int POOL_BYTES     = 65536;
  localparam int LEVELS         = 16;
  localparam int MIN_CHUNK_LOG2 = 3;

  localparam int OFF_W        = $clog2(POOL_BYTES);
  localparam int GRAN_W       = OFF_W - MIN_CHUNK_LOG2;
  localparam int LINK_W       = GRAN_W + 1;
  localparam int LINK_ENTRIES = POOL_BYTES >> MIN_CHUNK_LOG2;
  localparam int LINK_DEPTH   = LINK_ENTRIES + 1;
  localparam int STEP_W       = $clog2(LINK_DEPTH + 1);
  localparam int LVL_W        = $clog2(LEVELS) + 1;
  localparam int SIZE_W       = 17;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_MEM    = 3'd1;
  localparam logic [2:0] ST_OUTSIDE   = 3'd2;
  localparam logic [2:0] ST_NO_FREE   = 3'd3;
  localparam logic [2:0] ST_NULL_ADDR = 3'd4;
  localparam logic [2:0] ST_ZERO_SIZE = 3'd5;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] STRAT_LINEAR = 2'd0;
  localparam logic [1:0] STRAT_POOL   = 2'd1;
  localparam logic [1:0] STRAT_SEG    = 2'd2;
  localparam logic [1:0] STRAT_BUDDY  = 2'd3;

  localparam logic [1:0] REG_STRATEGY = 2'd0;
  localparam logic [1:0] REG_BASE     = 2'd1;
  localparam logic [1:0] REG_POOLSIZE = 2'd2;
  localparam logic [1:0] REG_CHUNKLOG = 2'd3;

  // block size for a log2, clamped at 2^17 (anything that large acts alike)
  function automatic logic [SIZE_W:0] blk_bytes(input logic [5:0] lg);
    blk_bytes = (lg < 6'(SIZE_W)) ? ((SIZE_W+1)'(1) << lg) : (SIZE_W+1)'(1) << SIZE_W;
  endfunction

  // mask that clears offset bits below a power-of-two size
  function automatic logic [OFF_W-1:0] low_mask(input logic [SIZE_W:0] sz);
    low_mask = (sz[SIZE_W:OFF_W] != '0) ? '0 : ~(sz[OFF_W-1:0] - OFF_W'(1));
  endfunction

  function automatic logic [4:0] msb17(input logic [SIZE_W-1:0] v);
    logic [4:0] r;
    r = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (v[i]) r = 5'(i);
    end
    msb17 = r;
  endfunction

  function automatic logic [SIZE_W-1:0] sat_add(input logic [SIZE_W-1:0] a,
                                                input logic [SIZE_W:0] b);
    logic [SIZE_W+1:0] s;
    s = (SIZE_W+2)'(a) + (SIZE_W+2)'(b);
    sat_add = (s[SIZE_W+1:SIZE_W] != '0) ? '1 : s[SIZE_W-1:0];
  endfunction

endpackage

FILE: rtl/mpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/memory_pool_allocator.sv
// Memory pool allocator top level: linear, chunk pool, segregated and buddy modes.
// Depends on mpa_pkg and mpa_ram (link memory).
//
//  channel   handshake               payload
//  config    cfg_write               cfg_index, cfg_data
//  request   start & !busy           command, request_size, align_bytes, target_address
//  result    done (one cycle)        status, block_address, granted_size, used_bytes
//
// Linear alignment runs a bit-serial modulo; a buddy free walks each list link by link
// through the link RAM and merges one level at a time.
// After reset or any config write the link RAM is set up: pool mode chains
// min(pool_size, 65536) >> max(chunk_size_log2, 3) chunks, one per cycle (up to 8192);
// buddy mode writes a single entry.
// busy is high during set-up and while a request is in work; results cannot be stalled.
module memory_pool_allocator import mpa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              start,
  output logic              busy,
  input  logic              command,
  input  logic [SIZE_W-1:0] request_size,
  input  logic [SIZE_W-1:0] align_bytes,
  input  logic [31:0]       target_address,
  output logic              done,
  output logic [2:0]        status,
  output logic [31:0]       block_address,
  output logic [SIZE_W-1:0] granted_size,
  output logic [SIZE_W-1:0] used_bytes
);

  typedef enum logic [15:0] {
    S_SETUP  = 16'h0001,
    S_SWEEP  = 16'h0002,
    S_IDLE   = 16'h0004,
    S_DECODE = 16'h0008,
    S_DIV    = 16'h0010,
    S_LIN    = 16'h0020,
    S_LVL    = 16'h0040,
    S_SEL    = 16'h0080,
    S_FIND   = 16'h0100,
    S_POP    = 16'h0200,
    S_POPW   = 16'h0400,
    S_SPLIT  = 16'h0800,
    S_PUSHB  = 16'h1000,
    S_MERGE  = 16'h2000,
    S_WALK   = 16'h4000,
    S_WALKW  = 16'h8000
  } state_t;

  state_t state;

  logic [1:0]        strat;
  logic [31:0]       base;
  logic [SIZE_W-1:0] psize;
  logic [4:0]        clog;
  logic [4:0]        eff;
  logic [SIZE_W-1:0] span;
  logic [3:0]        top;

  logic [LINK_W-1:0] heads [LEVELS];
  logic [SIZE_W-1:0] bump;
  logic [SIZE_W-1:0] used;

  logic              cmd;
  logic [SIZE_W-1:0] size;
  logic [SIZE_W-1:0] align;
  logic [SIZE_W-1:0] req;
  logic [31:0]       addr;
  logic [LVL_W-1:0]  lvl;
  logic [3:0]        tgt;
  logic [OFF_W-1:0]  off;
  logic [OFF_W-1:0]  bud;
  logic [LINK_W-1:0] link_h;
  logic [GRAN_W-1:0] prev;
  logic              at_head;
  logic              match;
  logic [STEP_W-1:0] steps;
  logic [31:0]       quo;
  logic [SIZE_W-1:0] rem;
  logic [4:0]        cnt;
  logic [31:0]       cur_addr;
  logic [SIZE_W-1:0] swoff;

  logic              mem_we;
  logic [GRAN_W-1:0] mem_wa;
  logic [LINK_W-1:0] mem_wd;
  logic [GRAN_W-1:0] mem_ra;
  logic [LINK_W-1:0] mem_rd;

  logic [4:0]        eff_c;
  logic [SIZE_W-1:0] region;
  logic [SIZE_W:0]   mn_c;
  logic [4:0]        t_c;
  logic              region_fit;
  logic [3:0]        top_c;
  logic [SIZE_W:0]   top_span;
  logic [SIZE_W:0]   mn;
  logic [SIZE_W:0]   bsz;
  logic [LINK_W-1:0] hsel;
  logic [31:0]       off32;
  logic [OFF_W-1:0]  pool_off;
  logic [OFF_W-1:0]  seg_off;
  logic [SIZE_W:0]   div_t;
  logic [SIZE_W-1:0] pad;
  logic [SIZE_W+1:0] lin_tot;
  logic [SIZE_W+1:0] seg_tot;
  logic [SIZE_W:0]   sw_next;
  logic [OFF_W-1:0]  split_off;
  logic [3:0]        lvl_lim;

  assign eff_c      = (clog < 5'(MIN_CHUNK_LOG2)) ? 5'(MIN_CHUNK_LOG2) : clog;
  assign region     = (psize > SIZE_W'(POOL_BYTES)) ? SIZE_W'(POOL_BYTES) : psize;
  assign mn_c       = blk_bytes({1'b0, eff_c});
  assign t_c        = msb17(region) - eff_c;
  assign region_fit = {1'b0, region} >= mn_c;
  assign top_c      = (t_c > 5'(LEVELS - 1)) ? 4'(LEVELS - 1) : t_c[3:0];
  assign top_span   = blk_bytes({1'b0, eff_c} + 6'(top_c));
  assign mn         = blk_bytes({1'b0, eff});
  assign bsz        = blk_bytes({1'b0, eff} + 6'(lvl));
  assign hsel       = heads[lvl[3:0]];
  assign off32      = addr - base;
  assign pool_off   = off32[OFF_W-1:0] & low_mask(mn);
  assign seg_off    = off & low_mask(mn);
  assign div_t      = {rem, quo[31]};
  assign pad        = (rem != '0) ? align - rem : '0;
  assign lin_tot    = (SIZE_W+2)'(bump) + (SIZE_W+2)'(pad) + (SIZE_W+2)'(size);
  assign seg_tot    = (SIZE_W+2)'(bump) + (SIZE_W+2)'(bsz);
  assign sw_next    = (SIZE_W+1)'(swoff) + (SIZE_W+1)'(mn[SIZE_W-1:0]);
  assign split_off  = off + bsz[OFF_W-1:0];
  assign lvl_lim    = (strat == STRAT_SEG) ? 4'(LEVELS - 1) : top;
  assign busy       = (state != S_IDLE);
  assign used_bytes = used;

  function automatic logic target_ok_pool();
    target_ok_pool = (strat == STRAT_POOL) && (addr != '0) && (off32 < 32'(span));
  endfunction

  // link RAM port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_ra = '0;
    case (state)
      S_SWEEP: begin
        if (strat == STRAT_POOL && swoff < span) begin
          mem_we = 1'b1;
          mem_wa = swoff[OFF_W-1:MIN_CHUNK_LOG2];
          mem_wd = (sw_next < (SIZE_W+1)'(span)) ?
                   {1'b1, sw_next[OFF_W-1:MIN_CHUNK_LOG2]} : '0;
        end else if (strat == STRAT_BUDDY && span != '0) begin
          mem_we = 1'b1;
        end
      end
      S_DECODE: begin
        if (cmd == CMD_FREE && strat == STRAT_POOL) begin
          mem_wa = pool_off[OFF_W-1:MIN_CHUNK_LOG2];
          mem_wd = hsel;
        end
        mem_we = cmd == CMD_FREE && target_ok_pool();
      end
      S_SEL: begin
        if (cmd == CMD_FREE && strat == STRAT_SEG) begin
          mem_we = 1'b1;
          mem_wa = seg_off[OFF_W-1:MIN_CHUNK_LOG2];
          mem_wd = hsel;
        end
      end
      S_PUSHB: begin
        mem_we = 1'b1;
        mem_wa = split_off[OFF_W-1:MIN_CHUNK_LOG2];
        mem_wd = hsel;
      end
      S_MERGE: begin
        if (!(5'(lvl) < 5'(top))) begin
          mem_we = 1'b1;
          mem_wa = off[OFF_W-1:MIN_CHUNK_LOG2];
          mem_wd = hsel;
        end
      end
      S_WALK: begin
        mem_ra = link_h[GRAN_W-1:0];
        if (!link_h[LINK_W-1] || steps == STEP_W'(LINK_DEPTH)) begin
          mem_we = 1'b1;
          mem_wa = off[OFF_W-1:MIN_CHUNK_LOG2];
          mem_wd = hsel;
        end
      end
      S_WALKW: begin
        if (match && !at_head) begin
          mem_we = 1'b1;
          mem_wa = prev;
          mem_wd = mem_rd;
        end
      end
      S_POP: mem_ra = hsel[GRAN_W-1:0];
      default: ;
    endcase
  end

  mpa_ram #(.WIDTH(LINK_W), .DEPTH(LINK_ENTRIES)) u_links (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (mem_wd),
    .raddr (mem_ra),
    .rdata (mem_rd)
  );

  always_ff @(posedge clk) begin
    logic done_next;
    done_next = 1'b0;
    if (rst) begin
      strat <= STRAT_LINEAR;
      base  <= '0;
      psize <= SIZE_W'(POOL_BYTES);
      clog  <= 5'd7;
      state <= S_SETUP;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STRATEGY: strat <= cfg_data[1:0];
        REG_BASE:     base  <= cfg_data;
        REG_POOLSIZE: psize <= cfg_data[SIZE_W-1:0];
        REG_CHUNKLOG: clog  <= cfg_data[4:0];
        default: ;
      endcase
      state <= S_SETUP;
    end else begin
      case (state)
        S_SETUP: begin
          eff   <= eff_c;
          bump  <= '0;
          used  <= '0;
          swoff <= '0;
          top   <= (strat == STRAT_BUDDY && region_fit) ? top_c : '0;
          for (int i = 0; i < LEVELS; i++) begin
            heads[i] <= ((strat == STRAT_POOL && i == 0 && region_fit) ||
                         (strat == STRAT_BUDDY && region_fit && 4'(i) == top_c)) ?
                        {1'b1, GRAN_W'(0)} : '0;
          end
          case (strat)
            STRAT_POOL:
              span <= mn_c[SIZE_W] ? '0 : region & ~(mn_c[SIZE_W-1:0] - SIZE_W'(1));
            STRAT_BUDDY: span <= region_fit ? top_span[SIZE_W-1:0] : '0;
            default: span <= region;
          endcase
          state <= S_SWEEP;
        end
        S_SWEEP: begin
          if (strat == STRAT_POOL && swoff < span) swoff <= sw_next[SIZE_W-1:0];
          else state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            cmd   <= command;
            size  <= request_size;
            align <= align_bytes;
            addr  <= target_address;
            lvl   <= '0;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          block_address <= '0;
          granted_size  <= '0;
          req           <= (cmd == CMD_ALLOC && strat == STRAT_BUDDY && align != '0 &&
                            size < align) ? align : size;
          if (cmd == CMD_ALLOC) begin
            if (size == '0) begin
              status <= ST_ZERO_SIZE; done_next = 1'b1; state <= S_IDLE;
            end else begin
              case (strat)
                STRAT_LINEAR: begin
                  cur_addr <= base + 32'(bump);
                  quo      <= base + 32'(bump);
                  rem      <= '0;
                  cnt      <= '0;
                  state    <= (align != '0) ? S_DIV : S_LIN;
                end
                STRAT_POOL: begin
                  if ({1'b0, size} > mn || !hsel[LINK_W-1]) begin
                    status <= ST_NO_MEM; done_next = 1'b1; state <= S_IDLE;
                  end else begin
                    state <= S_POP;
                  end
                end
                default: state <= S_LVL;
              endcase
            end
          end else begin
            off <= off32[OFF_W-1:0];
            if (addr == '0) begin
              status <= ST_NULL_ADDR; done_next = 1'b1; state <= S_IDLE;
            end else if (off32 >= 32'(span)) begin
              status <= ST_OUTSIDE; done_next = 1'b1; state <= S_IDLE;
            end else if (strat == STRAT_LINEAR) begin
              status <= ST_NO_FREE; done_next = 1'b1; state <= S_IDLE;
            end else if (strat != STRAT_POOL && size == '0) begin
              status <= ST_ZERO_SIZE; done_next = 1'b1; state <= S_IDLE;
            end else if (strat == STRAT_POOL) begin
              heads[0] <= {1'b1, mem_wa};
              used     <= (used > size) ? used - size : '0;
              status   <= ST_OK; done_next = 1'b1; state <= S_IDLE;
            end else begin
              state <= S_LVL;
            end
          end
        end
        S_DIV: begin
          rem   <= (div_t >= {1'b0, align}) ? SIZE_W'(div_t - {1'b0, align}) :
                   div_t[SIZE_W-1:0];
          quo   <= {quo[30:0], 1'b0};
          cnt   <= cnt + 5'd1;
          if (cnt == 5'd31) state <= S_LIN;
        end
        S_LIN: begin
          if (lin_tot > (SIZE_W+2)'(span)) begin
            status <= ST_NO_MEM;
          end else begin
            status        <= ST_OK;
            block_address <= cur_addr + 32'(pad);
            granted_size  <= size;
            bump          <= lin_tot[SIZE_W-1:0];
            used          <= sat_add(used, {1'b0, size});
          end
          done_next = 1'b1;
          state <= S_IDLE;
        end
        S_LVL: begin
          if (bsz < {1'b0, req} && 5'(lvl) < 5'(lvl_lim)) lvl <= lvl + LVL_W'(1);
          else state <= S_SEL;
        end
        S_SEL: begin
          if (cmd == CMD_FREE) begin
            if (strat == STRAT_SEG) begin
              heads[lvl[3:0]] <= {1'b1, mem_wa};
              used   <= (used > size) ? used - size : '0;
              status <= ST_OK; done_next = 1'b1; state <= S_IDLE;
            end else begin
              off   <= off & low_mask(bsz);
              state <= S_MERGE;
            end
          end else if (bsz < {1'b0, req} || (strat == STRAT_BUDDY && span == '0)) begin
            status <= ST_NO_MEM; done_next = 1'b1; state <= S_IDLE;
          end else if (strat == STRAT_BUDDY) begin
            tgt   <= lvl[3:0];
            state <= S_FIND;
          end else if (hsel[LINK_W-1]) begin
            state <= S_POP;
          end else if (seg_tot > (SIZE_W+2)'(span)) begin
            status <= ST_NO_MEM; done_next = 1'b1; state <= S_IDLE;
          end else begin
            status        <= ST_OK;
            block_address <= base + 32'(bump);
            granted_size  <= bsz[SIZE_W-1:0];
            bump          <= seg_tot[SIZE_W-1:0];
            used          <= sat_add(used, bsz);
            done_next     = 1'b1;
            state         <= S_IDLE;
          end
        end
        S_FIND: begin
          if (5'(lvl) > 5'(top)) begin
            status <= ST_NO_MEM; done_next = 1'b1; state <= S_IDLE;
          end else if (hsel[LINK_W-1]) begin
            state <= S_POP;
          end else begin
            lvl <= lvl + LVL_W'(1);
          end
        end
        S_POP: begin
          off   <= {hsel[GRAN_W-1:0], MIN_CHUNK_LOG2'(0)};
          state <= S_POPW;
        end
        S_POPW: begin
          heads[lvl[3:0]] <= mem_rd;
          if (strat == STRAT_BUDDY) begin
            state <= S_SPLIT;
          end else begin
            status        <= ST_OK;
            block_address <= base + 32'(off);
            granted_size  <= (strat == STRAT_POOL) ? mn[SIZE_W-1:0] : bsz[SIZE_W-1:0];
            used          <= sat_add(used, (strat == STRAT_POOL) ? mn : bsz);
            done_next     = 1'b1;
            state         <= S_IDLE;
          end
        end
        S_SPLIT: begin
          if (lvl[3:0] > tgt) begin
            lvl   <= lvl - LVL_W'(1);
            state <= S_PUSHB;
          end else begin
            status        <= ST_OK;
            block_address <= base + 32'(off);
            granted_size  <= bsz[SIZE_W-1:0];
            used          <= sat_add(used, bsz);
            done_next     = 1'b1;
            state         <= S_IDLE;
          end
        end
        S_PUSHB: begin
          heads[lvl[3:0]] <= {1'b1, mem_wa};
          state <= S_SPLIT;
        end
        S_MERGE: begin
          if (5'(lvl) < 5'(top)) begin
            bud     <= off ^ bsz[OFF_W-1:0];
            link_h  <= hsel;
            steps   <= '0;
            at_head <= 1'b1;
            state   <= S_WALK;
          end else begin
            heads[lvl[3:0]] <= {1'b1, mem_wa};
            used   <= (used > size) ? used - size : '0;
            status <= ST_OK; done_next = 1'b1; state <= S_IDLE;
          end
        end
        S_WALK: begin
          if (!link_h[LINK_W-1] || steps == STEP_W'(LINK_DEPTH)) begin
            heads[lvl[3:0]] <= {1'b1, mem_wa};
            used   <= (used > size) ? used - size : '0;
            status <= ST_OK; done_next = 1'b1; state <= S_IDLE;
          end else begin
            match <= (link_h[GRAN_W-1:0] == bud[OFF_W-1:MIN_CHUNK_LOG2]);
            state <= S_WALKW;
          end
        end
        S_WALKW: begin
          if (match) begin
            if (at_head) heads[lvl[3:0]] <= mem_rd;
            off   <= off & ~bsz[OFF_W-1:0];
            lvl   <= lvl + LVL_W'(1);
            state <= S_MERGE;
          end else begin
            prev    <= link_h[GRAN_W-1:0];
            at_head <= 1'b0;
            link_h  <= mem_rd;
            steps   <= steps + STEP_W'(1);
            state   <= S_WALK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
    done <= done_next;
  end

endmodule
